// ===== hdl/mpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// mpwm_pkg
// Shared types and constants of the multi-pin pwm port expander: item kinds,
// the item and result records and the stream field layout.
// ----------------------------------------------------------------------------
package mpwm_pkg;

  localparam int PIN_W     = 5;
  localparam int PCMP_W    = PIN_W + 1;
  localparam int FIELD_W   = 16;
  localparam int WORD_W    = 32;
  localparam int MODE_W    = 2;

  // input tdata layout, lowest bit first: pin, level, duty, period
  localparam int IN_DATA_W  = 40;
  localparam int IN_PIN_LO  = 0;
  localparam int IN_LVL_LO  = IN_PIN_LO + PIN_W;
  localparam int IN_DUTY_LO = IN_LVL_LO + 1;
  localparam int IN_PER_LO  = IN_DUTY_LO + FIELD_W;
  localparam int IN_USED_W  = IN_PER_LO + FIELD_W;

  // output tdata layout, lowest bit first: port_word, pin_level
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USED_W = WORD_W + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_SET   = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [PIN_W-1:0]   pin;
    logic               level;
    logic [FIELD_W-1:0] duty;
    logic [FIELD_W-1:0] period;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] port_word;
    logic              pin_level;
  } res_t;

endpackage

// ===== hdl/multi_pin_pwm_port_expander.sv =====
// ----------------------------------------------------------------------------
// multi_pin_pwm_port_expander
// A tick walks the per-pin table from acceptance on, one entry per cycle
// through its single read port with the write-back in the cycle after the
// read. A pin write, a pwm setting or an unused kind goes straight from
// idle to the response state. Each transaction in yields one
// transaction out carrying the whole port word and the addressed pin's level;
// the output register lets the next transaction in be taken while a result
// still waits. The table needs no clearing after reset.
// ----------------------------------------------------------------------------
module multi_pin_pwm_port_expander import mpwm_pkg::*; #(
  parameter int PIN_COUNT  = 32,
  parameter int TICK_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // pin[4:0], level, duty[15:0], period[15:0]
  input  logic [MODE_W-1:0]     s_axis_tuser,   // mode[1:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // port_word[31:0], pin_level
);

  localparam int AW = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
  localparam int EW = 3 * TICK_WIDTH;

  item_t          item;
  res_t           res;
  logic           res_valid;
  logic           res_ready;
  logic           tbl_wr_en;
  logic [AW-1:0]  tbl_wr_addr;
  logic [EW-1:0]  tbl_wr_data;
  logic           tbl_rd_en;
  logic [AW-1:0]  tbl_rd_addr;
  logic [EW-1:0]  tbl_rd_data;
  logic           out_vld_q;
  res_t           out_q;

  assign item.mode   = mode_e'(s_axis_tuser);
  assign item.pin    = s_axis_tdata[IN_PIN_LO +: PIN_W];
  assign item.level  = s_axis_tdata[IN_LVL_LO];
  assign item.duty   = s_axis_tdata[IN_DUTY_LO +: FIELD_W];
  assign item.period = s_axis_tdata[IN_PER_LO +: FIELD_W];

  mpwm_ctrl #(
    .PIN_COUNT  (PIN_COUNT),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (s_axis_tvalid),
    .item_ready_o  (s_axis_tready),
    .item_i        (item),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .tbl_wr_en_o   (tbl_wr_en),
    .tbl_wr_addr_o (tbl_wr_addr),
    .tbl_wr_data_o (tbl_wr_data),
    .tbl_rd_en_o   (tbl_rd_en),
    .tbl_rd_addr_o (tbl_rd_addr),
    .tbl_rd_data_i (tbl_rd_data)
  );

  mpwm_table #(
    .DEPTH (PIN_COUNT),
    .WIDTH (EW)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (tbl_wr_en),
    .wr_addr_i (tbl_wr_addr),
    .wr_data_i (tbl_wr_data),
    .rd_en_i   (tbl_rd_en),
    .rd_addr_i (tbl_rd_addr),
    .rd_data_o (tbl_rd_data)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, out_q.pin_level, out_q.port_word};

endmodule

// ===== hdl/mpwm_table.sv =====
// ----------------------------------------------------------------------------
// mpwm_table
// Per-pin pwm table: one write port, one read port with registered data.
// An entry never written reads as zero through its valid bit.
// ----------------------------------------------------------------------------
module mpwm_table #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 48,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [WIDTH-1:0] rd_data_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== hdl/mpwm_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpwm_ctrl
// Item sequencer: holds the port word, applies writes and settings, and on a
// tick walks the pin table with a read, update and write-back pipeline.
// ----------------------------------------------------------------------------
module mpwm_ctrl import mpwm_pkg::*; #(
  parameter int PIN_COUNT  = 32,
  parameter int TICK_WIDTH = 16,
  localparam int AW        = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1,
  localparam int EW        = 3 * TICK_WIDTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          item_valid_i,
  output logic          item_ready_o,
  input  item_t         item_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output res_t          res_o,
  output logic          tbl_wr_en_o,
  output logic [AW-1:0] tbl_wr_addr_o,
  output logic [EW-1:0] tbl_wr_data_o,
  output logic          tbl_rd_en_o,
  output logic [AW-1:0] tbl_rd_addr_o,
  input  logic [EW-1:0] tbl_rd_data_i
);

  localparam int CW = $clog2(PIN_COUNT + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_TICK = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic [PIN_COUNT-1:0]   port_q, port_d;
  logic [PIN_W-1:0]       pin_q, pin_d;
  logic [CW-1:0]          iss_q, iss_d;
  logic                   proc_vld_q;
  logic [AW-1:0]          proc_addr_q;

  logic                   accept;
  logic                   pin_ok;
  logic [AW-1:0]          pin_addr;
  logic                   iss_done;
  logic [TICK_WIDTH-1:0]  r_duty, r_per, r_cnt, new_cnt;
  logic                   cur_bit;
  logic                   proc_wr;
  logic [WORD_W-1:0]      word;

  assign item_ready_o = (state_q == ST_IDLE);
  assign accept       = item_valid_i && item_ready_o;
  assign pin_ok       = ({1'b0, item_i.pin} < PCMP_W'(PIN_COUNT));
  assign pin_addr     = item_i.pin[AW-1:0];
  assign iss_done     = (iss_q == CW'(PIN_COUNT));

  // one table read per cycle while walking; the data comes back in the following cycle
  assign tbl_rd_en_o   = (state_q == ST_TICK) && !iss_done;
  assign tbl_rd_addr_o = iss_q[AW-1:0];

  assign {r_duty, r_per, r_cnt} = tbl_rd_data_i;
  assign cur_bit = port_q[proc_addr_q];
  assign proc_wr = proc_vld_q && (r_duty != '0);

  always_comb begin
    if (r_cnt != '0) begin
      new_cnt = r_cnt - 1'b1;
    end else if (cur_bit) begin
      new_cnt = (r_per > r_duty) ? (r_per - r_duty) : '0;
    end else begin
      new_cnt = r_duty;
    end
  end

  // walk writes and setting writes never coincide: one is in tick, one in idle
  always_comb begin
    tbl_wr_en_o   = 1'b0;
    tbl_wr_addr_o = proc_addr_q;
    tbl_wr_data_o = {r_duty, r_per, new_cnt};
    if (proc_wr) begin
      tbl_wr_en_o = 1'b1;
    end else if (accept && (item_i.mode == MODE_SET) && pin_ok) begin
      tbl_wr_en_o   = 1'b1;
      tbl_wr_addr_o = pin_addr;
      tbl_wr_data_o = {TICK_WIDTH'(item_i.duty), TICK_WIDTH'(item_i.period),
                       {TICK_WIDTH{1'b0}}};
    end
  end

  always_comb begin
    state_d = state_q;
    port_d  = port_q;
    pin_d   = pin_q;
    iss_d   = iss_q;
    if (proc_wr && (r_cnt == '0)) begin
      port_d[proc_addr_q] = !cur_bit;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pin_d = item_i.pin;
          case (item_i.mode)
            MODE_TICK: begin
              iss_d   = '0;
              state_d = ST_TICK;
            end
            MODE_WRITE: begin
              if (pin_ok) begin
                port_d[pin_addr] = item_i.level;
              end
              state_d = ST_RESP;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_TICK: begin
        if (!iss_done) begin
          iss_d = iss_q + 1'b1;
        end else if (!proc_vld_q) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      port_q      <= '0;
      pin_q       <= '0;
      iss_q       <= '0;
      proc_vld_q  <= 1'b0;
      proc_addr_q <= '0;
    end else begin
      state_q     <= state_d;
      port_q      <= port_d;
      pin_q       <= pin_d;
      iss_q       <= iss_d;
      proc_vld_q  <= tbl_rd_en_o;
      proc_addr_q <= tbl_rd_addr_o;
    end
  end

  assign word            = WORD_W'(port_q);
  assign res_valid_o     = (state_q == ST_RESP);
  assign res_o.port_word = word;
  assign res_o.pin_level = word[pin_q];

endmodule
